@@ rtl/assert_macros.svh @@
// assertion macros shared by the merge core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kwm_pkg.sv @@
// shared types and codes for the k-way sorted merge core
package kwm_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int LANE_W = 2;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_POPPED    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_rd;
        logic scan_cmp;
        logic pop_end;
        logic load_out;
    } kwm_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             scan_last;
    } kwm_stat_t;

endpackage

@@ rtl/kwm_ctrl.sv @@
// controller state machine for the k-way sorted merge core
`include "assert_macros.svh"

module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  kwm_stat_t stat,
    output kwm_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.cmd == CMD_POP)
                    state_next = S_RD;
                else
                    state_next = S_DONE;
            end
            S_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                if (stat.scan_last)
                    state_next = S_END;
                else
                    state_next = S_RD;
            end
            S_END:
            begin
                cmd.pop_end = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == S_EXEC, "accept not executed")
    `ASSERT_NEXT(a_done_holds, state_reg == S_DONE && out_valid_reg && !out_ready,
                 state_reg == S_DONE && out_valid_reg, "result overwrote pending beat")

endmodule

@@ rtl/kwm_dp.sv @@
// datapath for the k-way sorted merge core: lane store, pointers and result
`include "assert_macros.svh"

module kwm_dp
    import kwm_pkg::*;
#(
    parameter int LANES      = 4,
    parameter int LANE_DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  kwm_cmd_t                 cmd,
    output kwm_stat_t                stat,
    input  logic [CMD_W-1:0]         command,
    input  logic [LANE_W-1:0]        lane,
    input  logic signed [DATA_W-1:0] value,
    output logic [ST_W-1:0]          status,
    output logic signed [DATA_W-1:0] merged_value,
    output logic [LANE_W-1:0]        source_lane
);

    localparam int LW = $clog2(LANES);
    localparam int CW = $clog2(LANE_DEPTH + 1);
    localparam int MD = LANES * LANE_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    logic [DATA_W-1:0] mem [0:MD-1];

    logic [CMD_W-1:0]         cmd_reg;
    logic [LANE_W-1:0]        lane_reg;
    logic [DATA_W-1:0]        value_reg;
    logic [CW-1:0]            fill_reg [0:LANES-1];
    logic [CW-1:0]            head_reg [0:LANES-1];
    logic [LW-1:0]            scan_idx_reg;
    logic [LW-1:0]            best_reg;
    logic [DATA_W-1:0]        best_val_reg;
    logic                     found_reg;
    logic [DATA_W-1:0]        rd_data_reg;
    logic                     rd_act_reg;
    logic [ST_W-1:0]          res_status_reg;
    logic [DATA_W-1:0]        res_value_reg;
    logic [LANE_W-1:0]        res_lane_reg;
    logic [ST_W-1:0]          out_status_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic [LANE_W-1:0]        out_lane_reg;

    logic [LW-1:0] lane_idx;
    logic          lane_ok;
    logic          append_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          scan_act;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          scan_last;
    logic          take_new;
    logic          any_active;

    assign lane_idx  = LW'(lane_reg);
    assign lane_ok   = int'(lane_reg) < LANES;
    assign append_ok = lane_ok && (int'(fill_reg[lane_idx]) < LANE_DEPTH);
    assign wr_en     = cmd.exec && (cmd_reg == CMD_APPEND) && append_ok;
    assign wr_addr   = AW'(int'(lane_idx) * LANE_DEPTH + int'(fill_reg[lane_idx]));

    assign scan_act  = head_reg[scan_idx_reg] < fill_reg[scan_idx_reg];
    assign rd_en     = cmd.scan_rd && scan_act;
    assign rd_addr   = AW'(int'(scan_idx_reg) * LANE_DEPTH + int'(head_reg[scan_idx_reg]));
    assign scan_last = int'(scan_idx_reg) == (LANES - 1);

    assign take_new  = rd_act_reg
                       && (!found_reg || ($signed(rd_data_reg) < $signed(best_val_reg)));

    always_comb
    begin
        any_active = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (head_reg[i] < fill_reg[i])
                any_active = 1'b1;
        end
    end

    // lane store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= value_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            lane_reg  <= lane;
            value_reg <= value;
        end
        if (cmd.scan_cmp && take_new)
            best_val_reg <= rd_data_reg;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_lane_reg   <= res_lane_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            scan_idx_reg   <= '0;
            best_reg       <= '0;
            found_reg      <= 1'b0;
            rd_act_reg     <= 1'b0;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
            res_lane_reg   <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                scan_idx_reg  <= '0;
                found_reg     <= 1'b0;
                res_value_reg <= '0;
                res_lane_reg  <= '0;
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (append_ok)
                        begin
                            fill_reg[lane_idx] <= fill_reg[lane_idx] + CW'(1);
                            res_status_reg     <= ST_OK;
                        end
                        else
                            res_status_reg <= ST_FULL;
                    end
                    CMD_CLEAR:
                    begin
                        for (int i = 0; i < LANES; i++)
                        begin
                            fill_reg[i] <= '0;
                            head_reg[i] <= '0;
                        end
                        res_status_reg <= ST_OK;
                    end
                    default:
                    begin
                        res_status_reg <= ST_OK;
                    end
                endcase
            end
            if (cmd.scan_rd)
                rd_act_reg <= scan_act;
            if (cmd.scan_cmp)
            begin
                if (take_new)
                begin
                    found_reg <= 1'b1;
                    best_reg  <= scan_idx_reg;
                end
                if (!scan_last)
                    scan_idx_reg <= scan_idx_reg + LW'(1);
            end
            if (cmd.pop_end)
            begin
                if (found_reg)
                begin
                    head_reg[best_reg] <= head_reg[best_reg] + CW'(1);
                    res_status_reg     <= ST_POPPED;
                    res_value_reg      <= best_val_reg;
                    res_lane_reg       <= LANE_W'(best_reg);
                end
                else
                begin
                    res_status_reg <= ST_EXHAUSTED;
                end
            end
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.scan_last = scan_last;

    assign status       = out_status_reg;
    assign merged_value = out_value_reg;
    assign source_lane  = out_lane_reg;

    `ASSERT_IMPLIES(a_pop_live, cmd.pop_end && found_reg,
                    head_reg[best_reg] < fill_reg[best_reg], "popped lane has no entry")
    `ASSERT_IMPLIES(a_exhausted, cmd.pop_end && !found_reg, !any_active,
                    "exhausted while a lane holds entries")

endmodule

@@ rtl/k_way_sorted_merge_core.sv @@
// top level of the k-way sorted merge core
// append, clear and other commands pass through the capture, execute and done states
// pop adds a read and a compare step per lane and an end step (at most one store read per lane)
// one beat at a time; the next input is taken only after the result is loaded for output
// reset: asynchronous active low, empties all lanes; store contents are not cleared
module k_way_sorted_merge_core
    import kwm_pkg::*;
#(
    parameter int LANES      = 4,
    parameter int LANE_DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         command,
    input  logic [LANE_W-1:0]        lane,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ST_W-1:0]          status,
    output logic signed [DATA_W-1:0] merged_value,
    output logic [LANE_W-1:0]        source_lane
);

    kwm_cmd_t  cmd;
    kwm_stat_t stat;

    kwm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kwm_dp #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .lane         (lane),
        .value        (value),
        .status       (status),
        .merged_value (merged_value),
        .source_lane  (source_lane)
    );

endmodule
